FILE: src/assert_macros.svh
// assertion macros shared by the cell collision rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define LBC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbc assertion failed");

// checked at every edge, reset included
`define LBC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("lbc assertion failed");

`endif

FILE: src/lbc_pkg.sv
// shared types, constants and helper functions of the d2q9 cell collision
`timescale 1ns / 1ps
package lbc_pkg;

  localparam int DATA_W        = 32;
  localparam int RHO_W         = 35;
  localparam int RR_W          = 18;
  localparam int OMEGA_BITS    = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_DIR       = 9;
  localparam int SAT_W         = 72;

  localparam logic [RR_W-1:0] RR_RESET = 18'd65536;

  localparam logic signed [SAT_W-1:0] SAT_HI = 72'sh0000000007fffffff;
  localparam logic signed [SAT_W-1:0] SAT_LO = -72'sh000000000080000000;

  typedef enum logic [1:0] {
    KIND_FLUID = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_FIXED = 2'd2,
    KIND_SPARE = 2'd3
  } cell_kind_e;

  typedef enum logic [3:0] {
    DIR_REST = 4'd0,
    DIR_EAST = 4'd1,
    DIR_NORTH = 4'd2,
    DIR_WEST = 4'd3,
    DIR_SOUTH = 4'd4,
    DIR_NE = 4'd5,
    DIR_NW = 4'd6,
    DIR_SW = 4'd7,
    DIR_SE = 4'd8
  } dir_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // lattice direction dotted with the velocity, y pointing down
  function automatic logic signed [DATA_W+1:0] proj(input dir_e d,
                                                     input logic signed [DATA_W-1:0] ux,
                                                     input logic signed [DATA_W-1:0] uy);
    logic signed [DATA_W+1:0] x;
    logic signed [DATA_W+1:0] y;
    logic signed [DATA_W+1:0] r;
    x = (DATA_W+2)'(ux);
    y = (DATA_W+2)'(uy);
    case (d)
      DIR_EAST:  r = x;
      DIR_NORTH: r = -y;
      DIR_WEST:  r = -x;
      DIR_SOUTH: r = y;
      DIR_NE:    r = x - y;
      DIR_NW:    r = -x - y;
      DIR_SW:    r = -x + y;
      DIR_SE:    r = x + y;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/lbc_div.sv
// pipelined restoring divider, one quotient bit per stage, for momentum over density
`timescale 1ns / 1ps
module lbc_div #(
  parameter int FRAC_BITS = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic [lbc_pkg::RHO_W-1:0]            num_i,
  input  logic [lbc_pkg::RHO_W-1:0]            den_i,
  input  logic                                 neg_i,
  output logic signed [lbc_pkg::DATA_W-1:0]    q_o
);
  import lbc_pkg::*;

  localparam int STAGES = FRAC_BITS + 1;
  localparam int RW     = RHO_W + FRAC_BITS + 1;
  localparam int QW     = FRAC_BITS + 1;

  logic [RW-1:0]    rem_q [STAGES];
  logic [RHO_W-1:0] den_q [STAGES];
  logic [QW-1:0]    quo_q [STAGES];
  logic             neg_q [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [RW-1:0]    rem_in;
    logic [RHO_W-1:0] den_in;
    logic [QW-1:0]    quo_in;
    logic             neg_in;
    logic [RW-1:0]    trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = RW'(num_i) << FRAC_BITS;
      assign den_in = den_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign neg_in = neg_q[j-1];
    end

    assign trial = RW'(den_in) << (FRAC_BITS - j);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[j] <= ge ? (rem_in - trial) : rem_in;
      den_q[j] <= den_in;
      quo_q[j] <= quo_in | (QW'(ge) << (FRAC_BITS - j));
      neg_q[j] <= neg_in;
    end
  end

  assign q_o = neg_q[STAGES-1] ? -DATA_W'(quo_q[STAGES-1]) : DATA_W'(quo_q[STAGES-1]);

endmodule

FILE: src/lbc_lane.sv
// one direction lane: equilibrium and bgk relaxation of a single population
`timescale 1ns / 1ps
module lbc_lane #(
  parameter int            FRAC_BITS = lbc_pkg::FRAC_BITS_DEF,
  parameter lbc_pkg::dir_e DIR       = lbc_pkg::DIR_REST,
  parameter int            WEIGHT    = 0
) (
  input  logic                              clk_i,
  input  logic [lbc_pkg::RR_W-1:0]          relax_rate_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] ux_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] uy_i,
  input  logic [lbc_pkg::RHO_W-1:0]         rho_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] f_i,
  input  logic                              wall_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] usq_i,
  output logic signed [lbc_pkg::DATA_W-1:0] new_o
);
  import lbc_pkg::*;

  localparam int RWP_W = RHO_W + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0]     W_FX    = (FRAC_BITS+1)'(WEIGHT);
  localparam logic signed [39:0]     ONE40   = 40'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0]     FEQ_RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [51:0]     DP_RND  = (52'sd1 <<< OMEGA_BITS) - 52'sd1;

  logic signed [DATA_W-1:0] eu_q, eu2_q, rw_q, rw3_q, poly_q;
  logic [RWP_W-1:0]         rwp_q;
  logic signed [63:0]       esqp_q, feqp_q;
  logic signed [32:0]       diff_q;
  logic signed [51:0]       dp_q;
  logic signed [DATA_W-1:0] f1_q, f2_q, f3_q, f4_q, f5_q, f6_q;
  logic                     w1_q, w2_q, w3_q, w4_q, w5_q, w6_q;

  logic [RWP_W-1:0]         rws;
  logic signed [DATA_W-1:0] esq_s;
  logic signed [39:0]       poly_sum;
  logic signed [63:0]       feq_adj;
  logic signed [DATA_W-1:0] feq;
  logic signed [51:0]       dp_adj;
  logic signed [51:0]       nf_sum;

  always_comb begin
    rws      = rwp_q >> FRAC_BITS;
    esq_s    = sat32(SAT_W'(esqp_q >>> FRAC_BITS));
    poly_sum = ONE40 + 40'sd3 * 40'(eu2_q) + ((40'sd9 * 40'(esq_s)) >>> 1)
               - ((40'sd3 * 40'(usq_i)) >>> 1);
    feq_adj  = feqp_q + ((feqp_q < 64'sd0) ? FEQ_RND : 64'sd0);
    feq      = sat32(SAT_W'(feq_adj >>> FRAC_BITS));
    dp_adj   = dp_q + ((dp_q < 52'sd0) ? DP_RND : 52'sd0);
    nf_sum   = (dp_adj >>> OMEGA_BITS) + 52'(f6_q);
  end

  always_ff @(posedge clk_i) begin
    eu_q   <= sat32(SAT_W'(proj(DIR, ux_i, uy_i)));
    rwp_q  <= RWP_W'(rho_i) * RWP_W'(W_FX);
    f1_q   <= f_i;
    w1_q   <= wall_i;

    esqp_q <= 64'(eu_q) * 64'(eu_q);
    rw_q   <= sat32(SAT_W'(signed'({1'b0, rws})));
    eu2_q  <= eu_q;
    f2_q   <= f1_q;
    w2_q   <= w1_q;

    poly_q <= sat32(SAT_W'(poly_sum));
    rw3_q  <= rw_q;
    f3_q   <= f2_q;
    w3_q   <= w2_q;

    feqp_q <= 64'(rw3_q) * 64'(poly_q);
    f4_q   <= f3_q;
    w4_q   <= w3_q;

    diff_q <= 33'(feq) - 33'(f4_q);
    f5_q   <= f4_q;
    w5_q   <= w4_q;

    dp_q   <= 52'(diff_q) * 52'(signed'({1'b0, relax_rate_i}));
    f6_q   <= f5_q;
    w6_q   <= w5_q;
  end

  assign new_o = w6_q ? f6_q : sat32(SAT_W'(nf_sum));

endmodule

FILE: src/lattice_boltzmann_cell_collision.sv
// top level of the d2q9 bgk cell collision: input stages, divider, lanes and merge
//
// One cell is taken on every clock cycle; busy never rises. Each result leaves on
// done_o after the input, sum and select registers and the velocity divider, which
// resolves one quotient bit per pipeline stage, and the velocity register. Nine
// direction lanes then build the equilibrium and relax each population in six
// stages, and a merge register follows. Results cannot be held off: the receiver
// must take every done_o strobe. relax_rate is written through the cfg channel,
// always ready, and must only change while no cell is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lattice_boltzmann_cell_collision #(
  parameter int FRAC_BITS = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lbc_pkg::RR_W-1:0]          cfg_data_i,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_rest_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_east_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_north_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_west_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_south_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_northeast_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_northwest_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_southwest_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] dist_southeast_i,
  input  logic [1:0]                        cell_kind_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] fixed_vel_x_i,
  input  logic signed [lbc_pkg::DATA_W-1:0] fixed_vel_y_i,
  output logic                              done_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_rest_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_east_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_north_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_west_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_south_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_northeast_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_northwest_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_southwest_o,
  output logic signed [lbc_pkg::DATA_W-1:0] new_southeast_o,
  output logic [lbc_pkg::RHO_W-1:0]         density_o,
  output logic signed [lbc_pkg::DATA_W-1:0] vel_x_o,
  output logic signed [lbc_pkg::DATA_W-1:0] vel_y_o
);
  import lbc_pkg::*;

  localparam int ONE      = 1 << FRAC_BITS;
  localparam int W_REST   = (2 * 4 * ONE + 9) / 18;
  localparam int W_AXIS   = (2 * ONE + 9) / 18;
  localparam int W_DIAG   = (2 * ONE + 36) / 72;
  localparam int DIV_LAT  = FRAC_BITS + 1;
  localparam int LANE_LAT = 6;
  localparam int LATENCY  = DIV_LAT + LANE_LAT + 5;

  localparam logic [RHO_W-1:0] RHO_ONE = RHO_W'(ONE);

  typedef struct {
    logic                     wall;
    logic                     fixed;
    logic [RHO_W-1:0]         rho;
    logic signed [DATA_W-1:0] f [NUM_DIR];
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
  } side_t;

  typedef struct packed {
    logic                     wall;
    logic [RHO_W-1:0]         rho;
    logic signed [DATA_W-1:0] ux;
    logic signed [DATA_W-1:0] uy;
  } tail_t;

  logic [RR_W-1:0]          rr_q;
  logic [LATENCY-1:0]       vld_q;
  side_t                    in_d, in_q, sum_d, sum_q, sel_d, sel_q, vel_q;
  side_t                    div_side_q [DIV_LAT];
  logic signed [35:0]       mx_q, my_q, mxs, mys;
  logic [RHO_W-1:0]         rho_sum;
  logic                     low;
  logic [RHO_W-1:0]         numx_q, numy_q;
  logic                     negx_q, negy_q;
  logic signed [DATA_W-1:0] qx, qy;
  logic signed [DATA_W-1:0] ux_q, uy_q;
  logic signed [63:0]       sqx_q, sqy_q;
  logic signed [DATA_W-1:0] usq_q;
  tail_t                    tail_q [LANE_LAT];
  logic signed [DATA_W-1:0] lane_new [NUM_DIR];
  logic signed [DATA_W-1:0] new_q [NUM_DIR];
  logic [RHO_W-1:0]         density_q;
  logic signed [DATA_W-1:0] vx_q, vy_q;
  logic signed [DATA_W-1:0] raw [NUM_DIR];

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q  <= RR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        rr_q <= cfg_data_i;
      end
      vld_q <= {vld_q[LATENCY-2:0], start && !busy};
    end
  end

  // input stage: kind decode and clamp
  always_comb begin
    raw[0] = dist_rest_i;
    raw[1] = dist_east_i;
    raw[2] = dist_north_i;
    raw[3] = dist_west_i;
    raw[4] = dist_south_i;
    raw[5] = dist_northeast_i;
    raw[6] = dist_northwest_i;
    raw[7] = dist_southwest_i;
    raw[8] = dist_southeast_i;
    in_d.wall  = (cell_kind_i == KIND_WALL) || (cell_kind_i == KIND_SPARE);
    in_d.fixed = (cell_kind_i == KIND_FIXED);
    in_d.rho   = '0;
    in_d.vx    = fixed_vel_x_i;
    in_d.vy    = fixed_vel_y_i;
    for (int k = 0; k < NUM_DIR; k++) begin
      in_d.f[k] = (in_d.wall || !raw[k][DATA_W-1]) ? raw[k] : '0;
    end
  end

  // density and momentum sums
  always_comb begin
    rho_sum = RHO_W'($unsigned(in_q.f[0])) + RHO_W'($unsigned(in_q.f[1]))
            + RHO_W'($unsigned(in_q.f[2])) + RHO_W'($unsigned(in_q.f[3]))
            + RHO_W'($unsigned(in_q.f[4])) + RHO_W'($unsigned(in_q.f[5]))
            + RHO_W'($unsigned(in_q.f[6])) + RHO_W'($unsigned(in_q.f[7]))
            + RHO_W'($unsigned(in_q.f[8]));
    sum_d     = in_q;
    sum_d.rho = rho_sum;
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    sum_q <= sum_d;
    mx_q <= 36'(in_q.f[1]) + 36'(in_q.f[5]) + 36'(in_q.f[8])
          - 36'(in_q.f[3]) - 36'(in_q.f[6]) - 36'(in_q.f[7]);
    my_q <= 36'(in_q.f[4]) + 36'(in_q.f[7]) + 36'(in_q.f[8])
          - 36'(in_q.f[2]) - 36'(in_q.f[5]) - 36'(in_q.f[6]);
  end

  // low density falls back to the lattice weights at unit density
  always_comb begin
    low   = !sum_q.wall && (sum_q.rho <= RHO_ONE);
    sel_d = sum_q;
    if (low) begin
      sel_d.rho = RHO_ONE;
      for (int k = 0; k < NUM_DIR; k++) begin
        sel_d.f[k] = (k == 0) ? DATA_W'(W_REST) : ((k <= 4) ? DATA_W'(W_AXIS) : DATA_W'(W_DIAG));
      end
    end
    mxs = low ? 36'sd0 : mx_q;
    mys = low ? 36'sd0 : my_q;
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    numx_q <= RHO_W'(mxs[35] ? -mxs : mxs);
    numy_q <= RHO_W'(mys[35] ? -mys : mys);
    negx_q <= mxs[35];
    negy_q <= mys[35];
  end

  lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .num_i (numx_q),
    .den_i (sel_q.rho),
    .neg_i (negx_q),
    .q_o   (qx)
  );

  lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .num_i (numy_q),
    .den_i (sel_q.rho),
    .neg_i (negy_q),
    .q_o   (qy)
  );

  always_ff @(posedge clk_i) begin
    div_side_q[0] <= sel_q;
    for (int s = 1; s < DIV_LAT; s++) begin
      div_side_q[s] <= div_side_q[s-1];
    end
    vel_q <= div_side_q[DIV_LAT-1];
    ux_q  <= div_side_q[DIV_LAT-1].fixed ? div_side_q[DIV_LAT-1].vx : qx;
    uy_q  <= div_side_q[DIV_LAT-1].fixed ? div_side_q[DIV_LAT-1].vy : qy;
  end

  // speed squared, shared by all lanes
  always_ff @(posedge clk_i) begin
    sqx_q <= 64'(ux_q) * 64'(ux_q);
    sqy_q <= 64'(uy_q) * 64'(uy_q);
    usq_q <= sat32(SAT_W'(sqx_q >>> FRAC_BITS) + SAT_W'(sqy_q >>> FRAC_BITS));
  end

  for (genvar g = 0; g < NUM_DIR; g++) begin : g_lane
    lbc_lane #(
      .FRAC_BITS (FRAC_BITS),
      .DIR       (dir_e'(g)),
      .WEIGHT    ((g == 0) ? W_REST : ((g <= 4) ? W_AXIS : W_DIAG))
    ) u_lane (
      .clk_i        (clk_i),
      .relax_rate_i (rr_q),
      .ux_i         (ux_q),
      .uy_i         (uy_q),
      .rho_i        (vel_q.rho),
      .f_i          (vel_q.f[g]),
      .wall_i       (vel_q.wall),
      .usq_i        (usq_q),
      .new_o        (lane_new[g])
    );
  end

  // merge: gather the lanes with density and velocity
  always_ff @(posedge clk_i) begin
    tail_q[0] <= '{wall: vel_q.wall, rho: vel_q.rho, ux: ux_q, uy: uy_q};
    for (int s = 1; s < LANE_LAT; s++) begin
      tail_q[s] <= tail_q[s-1];
    end
    for (int k = 0; k < NUM_DIR; k++) begin
      new_q[k] <= lane_new[k];
    end
    density_q <= tail_q[LANE_LAT-1].wall ? '0 : tail_q[LANE_LAT-1].rho;
    vx_q      <= tail_q[LANE_LAT-1].wall ? '0 : tail_q[LANE_LAT-1].ux;
    vy_q      <= tail_q[LANE_LAT-1].wall ? '0 : tail_q[LANE_LAT-1].uy;
  end

  assign done_o          = vld_q[LATENCY-1];
  assign new_rest_o      = new_q[0];
  assign new_east_o      = new_q[1];
  assign new_north_o     = new_q[2];
  assign new_west_o      = new_q[3];
  assign new_south_o     = new_q[4];
  assign new_northeast_o = new_q[5];
  assign new_northwest_o = new_q[6];
  assign new_southwest_o = new_q[7];
  assign new_southeast_o = new_q[8];
  assign density_o       = density_q;
  assign vel_x_o         = vx_q;
  assign vel_y_o         = vy_q;

  `LBC_ASSERT(a_fixed_latency, clk_i, rst_ni, (start && !busy) |-> ##(LATENCY) done_o)
  `LBC_ASSERT(a_density_floor, clk_i, rst_ni, done_o |-> (density_o == '0 || density_o >= RHO_ONE))
  `LBC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !done_o)

endmodule
